### rtl/utf8_stream_decoder_unit_macros.svh
// ----------------------------------------------------------------------------
// utf8_stream_decoder_unit_macros.svh
// Assertion shorthands for the UTF-8 stream decoder; clocked on clk,
// disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_DECODER_UNIT_MACROS_SVH
`define UTF8_STREAM_DECODER_UNIT_MACROS_SVH

// Same-cycle implication
`define UTF8SD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define UTF8SD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/utf8sd_pkg.sv
// ----------------------------------------------------------------------------
// utf8sd_pkg
// Types, constants and the lead-byte classifier of the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8sd_pkg;

  // Input request and result payloads
  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [20:0] code_unit;
    logic [2:0]  seq_len;
    logic        status;
    logic        last;
  } result_t;

  // Classified sequence passed from front to back
  typedef struct packed {
    logic        err;
    logic        split;
    logic [2:0]  len;
    logic [20:0] scalar;
  } job_t;

  // Action codes
  localparam logic ACT_BYTE    = 1'b0;
  localparam logic ACT_DISCARD = 1'b1;

  // Status codes
  localparam logic ST_VALID   = 1'b0;
  localparam logic ST_ILLEGAL = 1'b1;

  localparam logic [7:0]  LEAD2_MIN    = 8'hC2;
  localparam logic [7:0]  LEAD2_MAX    = 8'hDF;
  localparam logic [7:0]  LEAD3_MIN    = 8'hE0;
  localparam logic [7:0]  LEAD3_MAX    = 8'hEF;
  localparam logic [7:0]  LEAD4_MIN    = 8'hF0;
  localparam logic [7:0]  LEAD4_MAX    = 8'hF4;
  localparam logic [1:0]  CONT_TAG     = 2'b10;
  localparam logic [20:0] SCALAR_MAX   = 21'h10FFFF;
  localparam logic [20:0] SURR_MIN     = 21'h00D800;
  localparam logic [20:0] SURR_MAX     = 21'h00DFFF;
  localparam logic [20:0] BMP_MAX      = 21'h00FFFF;
  localparam logic [20:0] MIN_LEN2     = 21'h000080;
  localparam logic [20:0] MIN_LEN3     = 21'h000800;
  localparam logic [20:0] SUPP_BASE    = 21'h010000;
  localparam logic [20:0] HI_SURR_BASE = 21'h00D800;
  localparam logic [20:0] LO_SURR_BASE = 21'h00DC00;

  // Sequence length announced by a lead byte, 0 for an illegal lead
  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd0;
    if (b[7] == 1'b0) len = 3'd1;
    else if (b >= LEAD2_MIN && b <= LEAD2_MAX) len = 3'd2;
    else if (b >= LEAD3_MIN && b <= LEAD3_MAX) len = 3'd3;
    else if (b >= LEAD4_MIN && b <= LEAD4_MAX) len = 3'd4;
    return len;
  endfunction

endpackage

`default_nettype wire

### rtl/utf8sd_front.sv
// ----------------------------------------------------------------------------
// utf8sd_front
// Collects UTF-8 bytes, checks lead and continuation bytes, assembles and
// range-checks the scalar, and posts one job per finished or failed sequence.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8sd_front import utf8sd_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  accept,
  input  wire item_t item,
  input  wire logic  utf16_mode,
  output logic       job_wr,
  output job_t       job
);

  logic [23:0] seq_buf;
  logic [2:0]  have;
  logic [2:0]  need;
  logic [23:0] seq_buf_next;
  logic [2:0]  have_next;
  logic [2:0]  need_next;

  logic        lead_path;
  logic [2:0]  lead_len;
  logic [2:0]  len;
  logic        complete;
  logic        seq_err;
  logic        bad;
  logic [7:0]  b;
  logic [7:0]  b0, b1, b2, b3;
  logic [20:0] v;

  assign b         = item.data_byte;
  assign lead_path = (have == 3'd0) || (have >= need) || (need > 3'd4);
  assign lead_len  = lead_length(b);

  // Gather the bytes of the sequence with the new byte in its slot
  always_comb begin
    b0 = seq_buf[7:0];
    b1 = seq_buf[15:8];
    b2 = seq_buf[23:16];
    b3 = b;
    if (lead_path) begin
      b0       = b;
      len      = lead_len;
      complete = (lead_len == 3'd1);
      seq_err  = (lead_len == 3'd0);
    end else begin
      if (have == 3'd1) b1 = b;
      if (have == 3'd2) b2 = b;
      len      = need;
      complete = ((have + 3'd1) == need);
      seq_err  = (b[7:6] != CONT_TAG);
    end
  end

  // Assemble the scalar
  always_comb begin
    case (len)
      3'd1:    v = {13'd0, b0};
      3'd2:    v = {10'd0, b0[4:0], b1[5:0]};
      3'd3:    v = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
      default: v = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
    endcase
  end

  // Reject overlong forms, surrogates and out-of-range values
  assign bad = ((len == 3'd2) && (v < MIN_LEN2)) ||
               ((len == 3'd3) && (v < MIN_LEN3)) ||
               ((len == 3'd4) && (v < SUPP_BASE)) ||
               ((v >= SURR_MIN) && (v <= SURR_MAX)) ||
               (v > SCALAR_MAX);

  // Post a job on error or completion
  always_comb begin
    job_wr     = accept && (item.action == ACT_BYTE) && (seq_err || complete);
    job.err    = seq_err || bad;
    job.split  = utf16_mode && (v > BMP_MAX);
    job.len    = len;
    job.scalar = v;
  end

  // Advance the sequence state
  always_comb begin
    seq_buf_next = seq_buf;
    have_next    = have;
    need_next    = need;
    if (accept) begin
      if (item.action == ACT_DISCARD || seq_err || complete) begin
        seq_buf_next = '0;
        have_next    = 3'd0;
        need_next    = 3'd0;
      end else if (lead_path) begin
        seq_buf_next = {16'd0, b};
        have_next    = 3'd1;
        need_next    = lead_len;
      end else begin
        case (have[1:0])
          2'd1:    seq_buf_next[15:8]  = b;
          2'd2:    seq_buf_next[23:16] = b;
          default: seq_buf_next[7:0]   = b;
        endcase
        have_next = have + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 3'd0;
      need <= 3'd0;
    end else begin
      have <= have_next;
      need <= need_next;
    end
    seq_buf <= rst ? 24'd0 : seq_buf_next;
  end

endmodule

`default_nettype wire

### rtl/utf8sd_job_queue.sv
// ----------------------------------------------------------------------------
// utf8sd_job_queue
// Small first-in first-out queue of classified jobs between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8sd_job_queue import utf8sd_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr,
  input  wire job_t wr_job,
  input  wire logic rd,
  output job_t      head,
  output logic      not_empty,
  output logic      full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];
  assign do_wr     = wr && !full;
  assign do_rd     = rd && not_empty;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Move pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= bump(wr_ptr);
      if (do_rd) rd_ptr <= bump(rd_ptr);
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
  end

  // Store the incoming job
  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_job;
  end

endmodule

`default_nettype wire

### rtl/utf8sd_back.sv
// ----------------------------------------------------------------------------
// utf8sd_back
// Turns jobs into result requests: error, whole scalar, or a high and a low
// surrogate on two successive requests. Holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8sd_back import utf8sd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire job_t job,
  input  wire logic job_valid,
  output logic      job_rd,
  output result_t   result,
  output logic      empty,
  input  wire logic pop
);

  logic        out_valid;
  logic        out_valid_next;
  result_t     out_res;
  result_t     out_res_next;
  logic        low_pend;
  logic        low_pend_next;
  logic [9:0]  low10;
  logic [9:0]  low10_next;
  logic        load;
  logic [19:0] supp;

  assign empty  = !out_valid;
  assign result = out_res;
  assign load   = !out_valid || pop;
  assign supp   = 20'(job.scalar - SUPP_BASE);

  // Pick the next result: pending low unit first, then a new job
  always_comb begin
    out_valid_next = out_valid;
    out_res_next   = out_res;
    low_pend_next  = low_pend;
    low10_next     = low10;
    job_rd         = 1'b0;
    if (load) begin
      out_valid_next = 1'b0;
      if (low_pend) begin
        out_valid_next         = 1'b1;
        out_res_next.code_unit = LO_SURR_BASE + {11'd0, low10};
        out_res_next.seq_len   = 3'd0;
        out_res_next.status    = ST_VALID;
        out_res_next.last      = 1'b1;
        low_pend_next          = 1'b0;
      end else if (job_valid) begin
        job_rd         = 1'b1;
        out_valid_next = 1'b1;
        if (job.err) begin
          out_res_next.code_unit = '0;
          out_res_next.seq_len   = 3'd0;
          out_res_next.status    = ST_ILLEGAL;
          out_res_next.last      = 1'b1;
        end else if (job.split) begin
          out_res_next.code_unit = HI_SURR_BASE + {11'd0, supp[19:10]};
          out_res_next.seq_len   = job.len;
          out_res_next.status    = ST_VALID;
          out_res_next.last      = 1'b0;
          low_pend_next          = 1'b1;
          low10_next             = supp[9:0];
        end else begin
          out_res_next.code_unit = job.scalar;
          out_res_next.seq_len   = job.len;
          out_res_next.status    = ST_VALID;
          out_res_next.last      = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      low_pend  <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      low_pend  <= low_pend_next;
    end
    out_res <= out_res_next;
    low10   <= low10_next;
  end

endmodule

`default_nettype wire

### rtl/utf8_stream_decoder_unit.sv
// Timing: a byte that ends a sequence (or fails) is classified combinationally,
//   written into the job queue, then loaded into the output register once it is free;
//   a low surrogate appears on the edge that pops its high unit.
// Throughput: one byte per cycle while the job queue is not full;
//   the back emits one result per cycle while results are popped, a pair as two results.
// Reset: clears the partial sequence, job queue, output valid flag and utf16_mode.
// ----------------------------------------------------------------------------
// utf8_stream_decoder_unit
// UTF-8 byte stream to Unicode scalar / UTF-16 unit decoder, queue interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

`include "utf8_stream_decoder_unit_macros.svh"

module utf8_stream_decoder_unit import utf8sd_pkg::*; #(
  parameter int JOB_DEPTH = 2
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  output logic       full,
  input  wire item_t item,
  output logic       empty,
  input  wire logic  pop,
  output result_t    result,
  input  wire logic  cfg_we,
  input  wire logic  cfg_data
);

  logic utf16_mode;
  logic accept;
  logic job_wr;
  job_t job_in;
  job_t job_head;
  logic job_valid;
  logic job_rd;

  assign accept = push && !full;

  // Hold the mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      utf16_mode <= 1'b0;
    end else if (cfg_we) begin
      utf16_mode <= cfg_data;
    end
  end

  utf8sd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .item       (item),
    .utf16_mode (utf16_mode),
    .job_wr     (job_wr),
    .job        (job_in)
  );

  utf8sd_job_queue #(
    .DEPTH (JOB_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr        (job_wr),
    .wr_job    (job_in),
    .rd        (job_rd),
    .head      (job_head),
    .not_empty (job_valid),
    .full      (full)
  );

  utf8sd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (job_head),
    .job_valid (job_valid),
    .job_rd    (job_rd),
    .result    (result),
    .empty     (empty),
    .pop       (pop)
  );

  // Checks
  `UTF8SD_ASSERT_NOW(a_err_shape, !empty && (result.status == ST_ILLEGAL),
    (result.code_unit == 21'd0) && (result.seq_len == 3'd0) && result.last,
    "illegal result not zeroed")
  `UTF8SD_ASSERT_NOW(a_high_unit, !empty && !result.last,
    (result.code_unit >= HI_SURR_BASE) && (result.code_unit < LO_SURR_BASE) &&
    (result.seq_len == 3'd4), "non-last result is not a high surrogate")
  `UTF8SD_ASSERT_NEXT(a_low_follows, !empty && !result.last && pop,
    !empty && result.last && (result.code_unit >= LO_SURR_BASE) &&
    (result.code_unit <= SURR_MAX), "low surrogate did not follow")
  `UTF8SD_ASSERT_NOW(a_discard_quiet, accept && (item.action == ACT_DISCARD), !job_wr,
    "discard posted a job")

endmodule

`default_nettype wire
